FILE: hw/rtl/rsp_pkg.sv
// rsp_pkg: types, constants and Q16.16 helpers for the road segment projector.
// No dependencies; every other file but rsp_if imports it.
package rsp_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 10;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegCamX      = 3'd0,
    RegCamY      = 3'd1,
    RegCamZ      = 3'd2,
    RegViewDist  = 3'd3,
    RegHalfWidth = 3'd4,
    RegHalfHgt   = 3'd5,
    RegNearThr   = 3'd6,
    RegLenAdj    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic              first_segment;
    logic signed [31:0] seg_x;
    logic signed [31:0] seg_y;
    logic signed [31:0] curve_ddx;
    logic signed [31:0] hill_ddy;
    logic signed [31:0] near_z;
  } seg_in_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] scale;
    logic               new_horizon;
    logic [IdxW-1:0]    horizon_index;
    logic               behind_camera;
  } seg_out_t;

  // Front-end classification handed to the back end.
  typedef struct packed {
    seg_in_t            seg;
    logic               behind;
    logic [32:0]        zc;   // near_z - cam_z, positive when used
  } job_t;

  typedef struct packed {
    logic [31:0] cfg_wdata;
    logic [CfgIdxW-1:0] cfg_idx;
  } cfg_beat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Floor shift of an exact product: arithmetic shift floors toward -inf, but
  // the model rounds magnitude up for negatives, which is the same as floor.
  function automatic logic signed [31:0] qshift(input logic signed [63:0] p);
    logic signed [65:0] r;
    r = 66'(p >>> 16);
    return sat32(r);
  endfunction

endpackage

FILE: hw/rtl/rsp_if.sv
// rsp_if: valid/ready channel interface carrying a parameterized payload.
// Depends on nothing; payload types come from rsp_pkg at instantiation.
interface rsp_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/road_segment_projector_unit.sv
// road_segment_projector_unit: top level of the pseudo-3D road projector.
// Depends on rsp_pkg, rsp_if, rsp_front, rsp_queue, rsp_back.
//
// Projects road segments, nearest first, onto the screen in signed Q16.16.
// A segment with first_segment set starts a frame: slopes are seeded from
// the fractional progress, offsets cleared, horizon moved to the bottom row.
// For each segment the back end takes it, runs the radix-2 divider that
// forms view_distance / depth, then does four shared multiplier steps, one
// update step and one output step. A segment that starts a frame adds three
// multiplier steps to seed the slopes. A segment at or behind the camera
// skips the divider and the four projection steps. The output step stalls
// while the output register still holds an untaken beat. The front stage
// and a two-beat queue take new beats while the back end works.
// Configuration writes are taken at any time and must occur only while idle.
module road_segment_projector_unit #(
  parameter int unsigned MaxSegments = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  rsp_if.sink   cfg,
  rsp_if.sink   seg_in,
  rsp_if.source res_out
);
  import rsp_pkg::*;

  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q, near_thr_q;
  logic [30:0] view_dist_q, half_w_q, half_h_q, len_adj_q;

  // Configuration beats always accepted.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q     <= '0;
      cam_y_q     <= '0;
      cam_z_q     <= '0;
      near_thr_q  <= '0;
      view_dist_q <= 31'd65536;
      half_w_q    <= 31'd26214400;
      half_h_q    <= 31'd19660800;
      len_adj_q   <= 31'd65536;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.data.cfg_idx))
        RegCamX:      cam_x_q     <= cfg.data.cfg_wdata;
        RegCamY:      cam_y_q     <= cfg.data.cfg_wdata;
        RegCamZ:      cam_z_q     <= cfg.data.cfg_wdata;
        RegViewDist:  view_dist_q <= cfg.data.cfg_wdata[30:0];
        RegHalfWidth: half_w_q    <= cfg.data.cfg_wdata[30:0];
        RegHalfHgt:   half_h_q    <= cfg.data.cfg_wdata[30:0];
        RegNearThr:   near_thr_q  <= cfg.data.cfg_wdata;
        RegLenAdj:    len_adj_q   <= cfg.data.cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  logic  f_valid, f_ready, q_valid, q_ready;
  job_t  f_job, q_job;

  rsp_front u_front (
    .clk_i, .rst_ni, .cam_z_i(cam_z_q), .seg_in,
    .job_valid_o(f_valid), .job_o(f_job), .job_ready_i(f_ready)
  );

  rsp_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i(f_job),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_job)
  );

  rsp_back #(.MaxSegments(MaxSegments)) u_back (
    .clk_i, .rst_ni,
    .cam_x_i(cam_x_q), .cam_y_i(cam_y_q),
    .view_distance_i(view_dist_q), .half_width_i(half_w_q),
    .half_height_i(half_h_q), .near_threshold_i(near_thr_q),
    .length_adjust_i(len_adj_q),
    .job_valid_i(q_valid), .job_ready_o(q_ready), .job_i(q_job),
    .res_out
  );
endmodule

FILE: hw/rtl/rsp_front.sv
// rsp_front: accepts segments, computes relative depth and behind flag.
// Depends on rsp_pkg.
module rsp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic signed [31:0] cam_z_i,
  rsp_if.sink               seg_in,
  output logic              job_valid_o,
  output rsp_pkg::job_t     job_o,
  input  logic              job_ready_i
);
  import rsp_pkg::*;

  logic  valid_q;
  job_t  job_q;
  logic signed [32:0] zc;

  assign seg_in.ready = !valid_q || job_ready_i;
  assign zc = 33'(seg_in.data.near_z) - 33'(cam_z_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (seg_in.ready) begin
      valid_q <= seg_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_in.valid && seg_in.ready) begin
      job_q.seg    <= seg_in.data;
      job_q.behind <= (zc <= 33'sd0);
      job_q.zc     <= zc;
    end
  end

  assign job_valid_o = valid_q;
  assign job_o       = job_q;
endmodule

FILE: hw/rtl/rsp_queue.sv
// rsp_queue: two-entry FIFO between front and back end.
// Depends on rsp_pkg.
module rsp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rsp_pkg::job_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rsp_pkg::job_t out_data_o
);
  import rsp_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end
endmodule

FILE: hw/rtl/rsp_back.sv
// rsp_back: per-segment sequencer with a shared multiplier and a radix-2
// divider; holds frame state and the output register. Depends on rsp_pkg.
module rsp_back #(
  parameter int unsigned MaxSegments = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic signed [31:0] cam_x_i,
  input  logic signed [31:0] cam_y_i,
  input  logic [30:0]       view_distance_i,
  input  logic [30:0]       half_width_i,
  input  logic [30:0]       half_height_i,
  input  logic signed [31:0] near_threshold_i,
  input  logic [30:0]       length_adjust_i,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  rsp_pkg::job_t     job_i,
  rsp_if.source             res_out
);
  import rsp_pkg::*;

  localparam int unsigned SegLimit = (MaxSegments < 1024) ? MaxSegments : 1024;
  localparam logic [IdxW-1:0] CntMax = IdxW'(SegLimit - 1);

  typedef enum logic [10:0] {
    StIdle  = 11'b00000000001,
    StPct   = 11'b00000000010,
    StSlx   = 11'b00000000100,
    StSly   = 11'b00000001000,
    StDiv   = 11'b00000010000,
    StXp    = 11'b00000100000,
    StYp    = 11'b00001000000,
    StSx    = 11'b00010000000,
    StSy    = 11'b00100000000,
    StUpd   = 11'b01000000000,
    StOut   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  job_t   job_q;
  logic signed [31:0] slope_x_q, offset_x_q, slope_y_q, offset_y_q, horizon_row_q;
  logic [IdxW-1:0] horizon_seg_q, seg_cnt_q;
  logic signed [31:0] pct_q, scl_q, xp_q, yp_q, sx_q, sy_q;
  logic [5:0]  div_cnt_q;
  logic [47:0] quo_q;
  logic [32:0] rem_q;
  logic        out_valid_q;
  seg_out_t    res_q;
  seg_out_t    out_q;

  // Shared multiplier.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [31:0] mul_q;
  assign mul_p = mul_a * mul_b;
  assign mul_q = qshift(mul_p[63:0]);

  logic signed [31:0] xc, yc, hrow0, scr_y;
  logic signed [31:0] nslx, nsly;
  logic [33:0] rem_sh;
  logic        rem_ge;
  assign hrow0 = sat32(66'(half_height_i) * 66'sd2);
  assign xc = sat32(66'(job_q.seg.seg_x) - 66'(offset_x_q) - 66'(cam_x_i));
  assign yc = sat32(66'(job_q.seg.seg_y) - 66'(offset_y_q) - 66'(cam_y_i));
  assign rem_sh = {rem_q, quo_q[47]};
  assign rem_ge = rem_sh >= {1'b0, job_q.zc};
  // The saturated new slope feeds the offset.
  assign nslx = sat32(66'(slope_x_q) + 66'(job_q.seg.curve_ddx));
  assign nsly = sat32(66'(slope_y_q) + 66'(job_q.seg.hill_ddy));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StPct: begin
        mul_a = 33'(sat32(66'(near_threshold_i) - 66'(job_q.seg.near_z)));
        mul_b = 33'(length_adjust_i);
      end
      StSlx: begin mul_a = 33'(job_q.seg.curve_ddx); mul_b = 33'(pct_q); end
      StSly: begin mul_a = 33'(job_q.seg.hill_ddy);  mul_b = 33'(pct_q); end
      StXp:  begin mul_a = 33'(xc); mul_b = 33'(scl_q); end
      StYp:  begin mul_a = 33'(yc); mul_b = 33'(scl_q); end
      StSx:  begin mul_a = 33'(half_width_i);  mul_b = 33'(xp_q); end
      StSy:  begin mul_a = 33'(half_height_i); mul_b = 33'(yp_q); end
      default: ;
    endcase
  end

  assign scr_y = sat32(66'(half_height_i) - 66'(sy_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (job_valid_i) state_d = job_i.seg.first_segment ? StPct
                                         : (job_i.behind ? StUpd : StDiv);
      StPct:  state_d = StSlx;
      StSlx:  state_d = StSly;
      StSly:  state_d = job_q.behind ? StUpd : StDiv;
      StDiv:  if (div_cnt_q == 6'd47) state_d = StXp;
      StXp:   state_d = StYp;
      StYp:   state_d = StSx;
      StSx:   state_d = StSy;
      StSy:   state_d = StUpd;
      StUpd:  state_d = StOut;
      StOut:  if (!out_valid_q || res_out.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign job_ready_o   = (state_q == StIdle);
  assign res_out.valid = out_valid_q;
  assign res_out.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      out_valid_q   <= 1'b0;
      slope_x_q     <= '0;
      offset_x_q    <= '0;
      slope_y_q     <= '0;
      offset_y_q    <= '0;
      horizon_row_q <= 32'sd39321600;
      horizon_seg_q <= '0;
      seg_cnt_q     <= '0;
      div_cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (res_out.valid && res_out.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          div_cnt_q <= '0;
          if (job_valid_i && job_i.seg.first_segment) begin
            offset_x_q    <= '0;
            offset_y_q    <= '0;
            horizon_row_q <= hrow0;
            horizon_seg_q <= '0;
            seg_cnt_q     <= '0;
          end
        end
        StSlx: slope_x_q <= sat32(-66'(mul_q));
        StSly: slope_y_q <= sat32(-66'(mul_q));
        StDiv: div_cnt_q <= div_cnt_q + 6'd1;
        StUpd: begin
          if (!job_q.behind && (horizon_row_q > scr_y)) begin
            horizon_row_q <= scr_y;
            horizon_seg_q <= seg_cnt_q;
          end
          slope_x_q  <= nslx;
          offset_x_q <= sat32(66'(offset_x_q) + 66'(nslx));
          slope_y_q  <= nsly;
          offset_y_q <= sat32(66'(offset_y_q) + 66'(nsly));
          if (seg_cnt_q < CntMax) seg_cnt_q <= seg_cnt_q + 1'b1;
        end
        StOut: if (!out_valid_q || res_out.ready) out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        if (job_valid_i) job_q <= job_i;
        quo_q <= {1'b0, view_distance_i, 16'd0};
        rem_q <= '0;
      end
      StPct: pct_q <= mul_q;
      StDiv: begin
        rem_q <= rem_ge ? 33'(rem_sh - {1'b0, job_q.zc}) : rem_sh[32:0];
        quo_q <= {quo_q[46:0], rem_ge};
      end
      StXp: begin
        xp_q  <= mul_q;
      end
      StYp: yp_q <= mul_q;
      StSx: sx_q <= mul_q;
      StSy: sy_q <= mul_q;
      StUpd: begin
        res_q.behind_camera <= job_q.behind;
        res_q.new_horizon   <= !job_q.behind && (horizon_row_q > scr_y);
        res_q.horizon_index <= (!job_q.behind && (horizon_row_q > scr_y))
                               ? seg_cnt_q : horizon_seg_q;
        res_q.screen_x <= job_q.behind ? '0
                          : sat32(66'(half_width_i) + 66'(sx_q));
        res_q.screen_y <= job_q.behind ? '0 : scr_y;
        res_q.scale    <= job_q.behind ? '0 : scl_q;
      end
      // Hold the finished result until the output register is free.
      StOut: if (!out_valid_q || res_out.ready) out_q <= res_q;
      default: ;
    endcase
  end

  // Saturate the 48-bit quotient into the scale register once it completes.
  always_ff @(posedge clk_i) begin
    if (state_q == StXp && div_cnt_q == 6'd48) scl_q <= scl_q;
    else if (state_q == StDiv && div_cnt_q == 6'd47)
      scl_q <= (|quo_q[46:30] || rem_ge && quo_q[30]) ? 32'sh7FFFFFFF
               : {1'b0, quo_q[29:0], rem_ge};
  end
endmodule

FILE: verif/road_segment_projector_unit_tb.sv
// road_segment_projector_unit_tb: self-checking bench for the road segment projector.
// Depends on rsp_pkg, rsp_if and road_segment_projector_unit; predicts every result beat.
`timescale 1ns / 1ps

module road_segment_projector_unit_tb;
  import rsp_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 90;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned MaxSegCount = 1024;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rsp_if #(.payload_t(cfg_beat_t)) cfg_ch ();
  rsp_if #(.payload_t(seg_in_t))   seg_ch ();
  rsp_if #(.payload_t(seg_out_t))  res_ch ();

  road_segment_projector_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg     (cfg_ch),
    .seg_in  (seg_ch),
    .res_out (res_ch)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the configuration registers.
  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q, near_thr_q;
  logic signed [32:0] view_dist_q, half_w_q, half_h_q, len_adj_q;
  // Shadow copy of the per-frame projection state.
  logic signed [31:0] slope_x_q, offset_x_q, slope_y_q, offset_y_q, horizon_row_q;
  logic [IdxW-1:0]    horizon_seg_q, seg_count_q;

  seg_out_t expected_beats[$];
  int unsigned n_errors = 0;
  int unsigned cycle_count = 0;
  bit idle_en = 1'b1;      // random gaps on both sides
  bit hold_rx_req = 1'b0;  // ask the receiver for one long hold-off

  // Saturate to the signed 32-bit range.
  function automatic logic signed [31:0] clip32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Exact product, floor shift by 16, saturate.
  function automatic logic signed [31:0] q16_mul(input logic signed [65:0] a,
                                                  input logic signed [65:0] b);
    logic signed [65:0] p;
    p = a * b;
    return clip32(p >>> 16);
  endfunction

  // Advance the shadow state by one segment and queue the result it causes.
  task automatic project_segment(input seg_in_t s);
    logic signed [65:0] zc, num, quot;
    logic signed [31:0] pct, xc, yc, xp, yp;
    seg_out_t r;
    r = '0;
    if (s.first_segment) begin
      pct = q16_mul(clip32(66'(near_thr_q) - 66'(s.near_z)), 66'(len_adj_q));
      slope_x_q = clip32(66'sd0 - 66'(q16_mul(66'(s.curve_ddx), 66'(pct))));
      slope_y_q = clip32(66'sd0 - 66'(q16_mul(66'(s.hill_ddy), 66'(pct))));
      offset_x_q = '0;
      offset_y_q = '0;
      horizon_row_q = clip32(66'(half_h_q) + 66'(half_h_q));
      horizon_seg_q = '0;
      seg_count_q = '0;
    end
    zc = 66'(s.near_z) - 66'(cam_z_q);
    r.behind_camera = (zc <= 0);
    if (!r.behind_camera) begin
      num = 66'(view_dist_q) <<< 16;
      quot = num / zc;
      r.scale = clip32(quot);
      xc = clip32(66'(s.seg_x) - 66'(offset_x_q) - 66'(cam_x_q));
      yc = clip32(66'(s.seg_y) - 66'(offset_y_q) - 66'(cam_y_q));
      xp = q16_mul(66'(xc), 66'(r.scale));
      yp = q16_mul(66'(yc), 66'(r.scale));
      r.screen_x = clip32(66'(half_w_q) + 66'(q16_mul(66'(half_w_q), 66'(xp))));
      r.screen_y = clip32(66'(half_h_q) - 66'(q16_mul(66'(half_h_q), 66'(yp))));
      if (horizon_row_q > r.screen_y) begin
        horizon_row_q = r.screen_y;
        horizon_seg_q = seg_count_q;
        r.new_horizon = 1'b1;
      end
    end
    slope_x_q = clip32(66'(slope_x_q) + 66'(s.curve_ddx));
    offset_x_q = clip32(66'(offset_x_q) + 66'(slope_x_q));
    slope_y_q = clip32(66'(slope_y_q) + 66'(s.hill_ddy));
    offset_y_q = clip32(66'(offset_y_q) + 66'(slope_y_q));
    if (seg_count_q < IdxW'(MaxSegCount - 1)) seg_count_q = seg_count_q + 1'b1;
    r.horizon_index = horizon_seg_q;
    expected_beats.insert(expected_beats.size(), r);
  endtask

  // Send one segment beat; called at a falling edge, returns at a falling edge.
  task automatic send_segment(input seg_in_t s);
    seg_ch.valid = 1'b1;
    seg_ch.data = s;
    do @(posedge clk_i); while (!seg_ch.ready);
    project_segment(s);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      seg_ch.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.data.cfg_idx = idx;
    cfg_ch.data.cfg_wdata = val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      RegCamX:      cam_x_q = val;
      RegCamY:      cam_y_q = val;
      RegCamZ:      cam_z_q = val;
      RegViewDist:  view_dist_q = {2'b00, val[30:0]};
      RegHalfWidth: half_w_q = {2'b00, val[30:0]};
      RegHalfHgt:   half_h_q = {2'b00, val[30:0]};
      RegNearThr:   near_thr_q = val;
      RegLenAdj:    len_adj_q = {2'b00, val[30:0]};
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  // Drop valid, wait out every expected beat, then let the back end settle.
  task automatic drain();
    seg_ch.valid = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_word(input bit keep_sane);
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return keep_sane ? 32'($urandom_range(0, 32'h00100000)) : 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_all_regs(input bit extreme);
    cfg_reg_e idx;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_e'(i);
      write_reg(idx, extreme ? pick_word(1'b0) : $urandom);
    end
  endtask

  // Sensible camera and screen so that frames reach deep into the horizon logic.
  task automatic write_sane_view();
    write_reg(RegCamX, 32'($urandom_range(0, 200000)) - 32'd100000);
    write_reg(RegCamY, 32'($urandom_range(65536, 1500 << 16)));
    write_reg(RegCamZ, 32'($urandom_range(0, 1000 << 16)));
    write_reg(RegViewDist, 32'($urandom_range(1 << 16, 400 << 16)));
    write_reg(RegHalfWidth, 32'($urandom_range(1, 640)) << 16);
    write_reg(RegHalfHgt, 32'($urandom_range(1, 480)) << 16);
    write_reg(RegNearThr, 32'($urandom_range(0, 2000 << 16)));
    write_reg(RegLenAdj, 32'($urandom_range(1, 1024)));
  endtask

  function automatic seg_in_t noise_segment();
    seg_in_t s;
    s.first_segment = $urandom_range(0, 1);
    s.seg_x = $urandom;
    s.seg_y = $urandom;
    s.curve_ddx = $urandom;
    s.hill_ddy = $urandom;
    s.near_z = $urandom;
    return s;
  endfunction

  // One well-formed frame: depths rise from the camera, small curves and hills.
  task automatic send_frame(input int unsigned n_segs);
    seg_in_t s;
    logic signed [31:0] z;
    z = cam_z_q + 32'($urandom_range(0, 300000)) - 32'd50000;
    for (int unsigned k = 0; k < n_segs; k++) begin
      s.first_segment = (k == 0);
      s.seg_x = 32'($urandom_range(0, 4 << 16)) - 32'(2 << 16);
      s.seg_y = 32'($urandom_range(0, 80 << 16)) - 32'(40 << 16);
      s.curve_ddx = 32'($urandom_range(0, 4096)) - 32'd2048;
      s.hill_ddy = 32'($urandom_range(0, 8192)) - 32'd4096;
      s.near_z = z;
      z = z + 32'($urandom_range(1 << 14, 200 << 16));
      send_segment(s);
    end
  endtask

  // Segments before any first segment run against the reset state.
  task automatic test_reset_state();
    seg_in_t s;
    s = '0;
    s.near_z = 32'sd65536;
    s.seg_y = -32'sd65536;
    send_segment(s);
    s.near_z = 32'sd0;
    send_segment(s);
    s.near_z = 32'sh7FFFFFFF;
    s.seg_x = 32'sh7FFFFFFF;
    send_segment(s);
    drain();
  endtask

  // Field extremes, behind the camera, saturation on every path.
  task automatic test_directed_edges();
    seg_in_t s;
    write_reg(RegCamZ, 32'h0);
    write_reg(RegViewDist, 32'h7FFFFFFF);
    write_reg(RegHalfWidth, 32'h7FFFFFFF);
    write_reg(RegHalfHgt, 32'h7FFFFFFF);
    write_reg(RegNearThr, 32'h80000000);
    write_reg(RegLenAdj, 32'h7FFFFFFF);
    s = '0;
    s.first_segment = 1'b1;
    s.near_z = 32'sh7FFFFFFF;
    s.curve_ddx = 32'sh7FFFFFFF;
    s.hill_ddy = 32'sh80000000;
    send_segment(s);
    s = '0;
    s.near_z = 32'sd1;               // tiny depth: scale saturates
    s.seg_x = 32'sh80000000;
    s.seg_y = 32'sh7FFFFFFF;
    send_segment(s);
    s.near_z = 32'sh80000000;        // behind camera, offsets still move
    s.curve_ddx = 32'sh80000000;
    s.hill_ddy = 32'sh7FFFFFFF;
    send_segment(s);
    s.near_z = 32'sd0;               // depth exactly at the camera
    send_segment(s);
    s = '1;
    send_segment(s);
    s = '0;
    s.first_segment = 1'b1;
    s.near_z = 32'sh80000000;        // first segment behind the camera
    send_segment(s);
    drain();
    write_reg(RegViewDist, 32'h0);
    write_reg(RegHalfWidth, 32'h0);
    write_reg(RegHalfHgt, 32'h0);
    write_reg(RegLenAdj, 32'h0);
    write_reg(RegCamX, 32'h80000000);
    write_reg(RegCamY, 32'h7FFFFFFF);
    write_reg(RegCamZ, 32'h80000000);
    write_reg(RegNearThr, 32'h7FFFFFFF);
    for (int i = 0; i < 4; i++) send_segment(noise_segment());
    drain();
  endtask

  // Random frames, some noise, with a fresh setting each phase.
  task automatic test_random_frames(input int unsigned n_items);
    int unsigned sent, len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 5) == 0) begin
        drain();
        if ($urandom_range(0, 3) == 0) write_all_regs($urandom_range(0, 1));
        else write_sane_view();
      end
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(2, 30);
        send_frame(len);
        sent += len;
      end else begin
        send_segment(noise_segment());
        sent++;
      end
    end
    drain();
  endtask

  // Receiver holds off while beats keep coming; the block must stall its input.
  task automatic test_output_backpressure();
    write_sane_view();
    hold_rx_req = 1'b1;
    send_frame(40);
    drain();
  endtask

  // Sender stops until every result is in, then resumes mid frame.
  task automatic test_sender_pause();
    seg_in_t s;
    send_frame(10);
    seg_ch.valid = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    s = noise_segment();
    s.first_segment = 1'b0;
    s.near_z = cam_z_q + 32'sd65536;
    send_segment(s);
    drain();
  endtask

  // Receiver ready: random stalls, one long hold-off on request.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rx_req) begin
        res_ch.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_rx_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        res_ch.ready = 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    seg_out_t exp_b, got;
    if (res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        n_errors++;
      end else begin
        exp_b = expected_beats.pop_front();
        if (got.screen_x !== exp_b.screen_x) begin
          $display("%0t: screen_x exp %h got %h", $time, exp_b.screen_x, got.screen_x);
          n_errors++;
        end
        if (got.screen_y !== exp_b.screen_y) begin
          $display("%0t: screen_y exp %h got %h", $time, exp_b.screen_y, got.screen_y);
          n_errors++;
        end
        if (got.scale !== exp_b.scale) begin
          $display("%0t: scale exp %h got %h", $time, exp_b.scale, got.scale);
          n_errors++;
        end
        if (got.new_horizon !== exp_b.new_horizon) begin
          $display("%0t: new_horizon exp %b got %b", $time, exp_b.new_horizon,
                   got.new_horizon);
          n_errors++;
        end
        if (got.horizon_index !== exp_b.horizon_index) begin
          $display("%0t: horizon_index exp %0d got %0d", $time, exp_b.horizon_index,
                   got.horizon_index);
          n_errors++;
        end
        if (got.behind_camera !== exp_b.behind_camera) begin
          $display("%0t: behind_camera exp %b got %b", $time, exp_b.behind_camera,
                   got.behind_camera);
          n_errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    seg_ch.valid = 1'b0;
    seg_ch.data = '0;
    // Reset values of the shadow registers and state.
    cam_x_q = '0; cam_y_q = '0; cam_z_q = '0; near_thr_q = '0;
    view_dist_q = 33'sd65536; half_w_q = 33'sd26214400;
    half_h_q = 33'sd19660800; len_adj_q = 33'sd65536;
    slope_x_q = '0; offset_x_q = '0; slope_y_q = '0; offset_y_q = '0;
    horizon_row_q = 32'sd39321600;
    horizon_seg_q = '0; seg_count_q = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_state();
    test_directed_edges();
    test_output_backpressure();
    test_sender_pause();
    test_random_frames(600);
    idle_en = 1'b0;          // closing stretch runs flat out
    write_sane_view();
    test_random_frames(150);

    drain();
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: road_segment_projector_unit.f
hw/rtl/rsp_pkg.sv
hw/rtl/rsp_if.sv
hw/rtl/rsp_front.sv
hw/rtl/rsp_queue.sv
hw/rtl/rsp_back.sv
hw/rtl/road_segment_projector_unit.sv
verif/road_segment_projector_unit_tb.sv
